>>> hw/rtl/assert_macros.svh
// Assertion helpers included by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/itd_pkg.sv
package itd_pkg;

   // Default sizes.
   localparam int WORD_BITS_DEFAULT = 64;
   localparam int MAX_CHARS_DEFAULT = 64;
   localparam int DIGIT_BITS        = 4;

   // Mode codes on req_func.
   localparam logic [2:0] FUNC_UNSIGNED_DEC = 3'd0;
   localparam logic [2:0] FUNC_SIGNED_DEC   = 3'd1;
   localparam logic [2:0] FUNC_FORCED_SIGN  = 3'd2;
   localparam logic [2:0] FUNC_HEX_LOWER    = 3'd3;
   localparam logic [2:0] FUNC_HEX_UPPER    = 3'd4;

   // ASCII codes.
   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_MINUS = 7'h2D;
   localparam logic [6:0] CHAR_PLUS  = 7'h2B;
   localparam logic [6:0] CHAR_LOWER_A = 7'h61;
   localparam logic [6:0] CHAR_UPPER_A = 7'h41;

   typedef logic [DIGIT_BITS-1:0] digit_type;

   // Maps one digit value to its ASCII character.
   function automatic logic [6:0] digit_char(input digit_type d, input logic upper);
      logic [6:0] base;
      base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      if (d < digit_type'(10)) begin
         digit_char = CHAR_ZERO + 7'(d);
      end else begin
         digit_char = base + 7'(d) - 7'd10;
      end
   endfunction

endpackage

>>> hw/rtl/integer_to_text_digits_unit.sv
// Converts one word to ASCII text, most significant character first, one
// character per strobed beat on rsp_valid, with rsp_last on the final one.
// An item is taken when start is high and busy is low; busy stays high until
// the final character has been launched. Per item, the shared add-3 and shift
// unit first takes in the magnitude one input bit per cycle (plain shift in the
// hex modes), then the digit store is scanned down past the leading-zero digits,
// then the characters are emitted (sign, padding zeros, digits). The receiver
// cannot stall: every character appears for exactly one cycle and must be taken
// then.
`include "assert_macros.svh"

module integer_to_text_digits_unit #(
   parameter int WORD_BITS = itd_pkg::WORD_BITS_DEFAULT,
   parameter int MAX_CHARS = itd_pkg::MAX_CHARS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_number,
   input  logic [2:0]  req_func,
   input  logic [5:0]  req_min_width,
   output logic        rsp_valid,
   output logic [6:0]  rsp_character,
   output logic        rsp_last
);

   // Enough decimal digits for any WORD_BITS value (log10(2) ~ 0.30103).
   localparam int STORE_DEPTH = (WORD_BITS * 30103) / 100000 + 1;
   localparam int IDX_BITS    = $clog2(STORE_DEPTH);
   localparam int CNT_BITS    = $clog2(WORD_BITS);
   localparam int PAD_BITS    = $clog2(MAX_CHARS);

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CONV = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_SIGN = 3'd3;
   localparam logic [2:0] S_PAD  = 3'd4;
   localparam logic [2:0] S_DIG  = 3'd5;

   logic [2:0]                 state_ff, state_in;
   logic [WORD_BITS-1:0]       mag_ff, mag_in;
   logic [CNT_BITS-1:0]        bits_ff, bits_in;
   itd_pkg::digit_type         digits_ff [STORE_DEPTH];
   itd_pkg::digit_type         digits_in [STORE_DEPTH];
   logic [IDX_BITS-1:0]        idx_ff, idx_in;
   logic [PAD_BITS-1:0]        pad_ff, pad_in;
   logic [PAD_BITS-1:0]        mw_ff, mw_in;
   logic                       dec_ff, dec_in;
   logic                       upper_ff, upper_in;
   logic                       sign_ff, sign_in;
   logic [6:0]                 sign_ch_ff, sign_ch_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [6:0]                 rsp_character_ff, rsp_character_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       accept;
   logic                       is_signed;
   logic                       negative;
   logic [WORD_BITS-1:0]       word;
   logic [5:0]                 mw_sat;
   logic [PAD_BITS-1:0]        count;
   itd_pkg::digit_type         corr [STORE_DEPTH];
   itd_pkg::digit_type         cur_digit;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // Input decode: sign handling and minimum-width saturation.
   assign word      = req_number[WORD_BITS-1:0];
   assign is_signed = (req_func == itd_pkg::FUNC_SIGNED_DEC) ||
                      (req_func == itd_pkg::FUNC_FORCED_SIGN);
   assign negative  = is_signed && word[WORD_BITS-1];
   assign mw_sat    = (req_min_width > 6'(MAX_CHARS - 1)) ? 6'(MAX_CHARS - 1)
                                                           : req_min_width;

   // Shared unit: add 3 to every decimal digit of five or more.
   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if (dec_ff && (digits_ff[i] >= itd_pkg::digit_type'(5))) begin
            corr[i] = digits_ff[i] + itd_pkg::digit_type'(3);
         end else begin
            corr[i] = digits_ff[i];
         end
      end
   end

   assign cur_digit = digits_ff[idx_ff];
   assign count     = PAD_BITS'(idx_ff) + PAD_BITS'(1);

   // Sequencer.
   always_comb begin
      state_in         = state_ff;
      mag_in           = mag_ff;
      bits_in          = bits_ff;
      digits_in        = digits_ff;
      idx_in           = idx_ff;
      pad_in           = pad_ff;
      mw_in            = mw_ff;
      dec_in           = dec_ff;
      upper_in         = upper_ff;
      sign_in          = sign_ff;
      sign_ch_in       = sign_ch_ff;
      rsp_valid_in     = 1'b0;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mag_in     = negative ? (WORD_BITS'(0) - word) : word;
               bits_in    = CNT_BITS'(WORD_BITS - 1);
               for (int i = 0; i < STORE_DEPTH; i++) begin
                  digits_in[i] = '0;
               end
               mw_in      = PAD_BITS'(mw_sat);
               dec_in     = !((req_func == itd_pkg::FUNC_HEX_LOWER) ||
                              (req_func == itd_pkg::FUNC_HEX_UPPER));
               upper_in   = (req_func == itd_pkg::FUNC_HEX_UPPER);
               sign_in    = negative || (req_func == itd_pkg::FUNC_FORCED_SIGN);
               sign_ch_in = negative ? itd_pkg::CHAR_MINUS : itd_pkg::CHAR_PLUS;
               state_in   = S_CONV;
            end
         end
         S_CONV: begin
            // Correct, then shift one bit of the magnitude into the digit chain.
            for (int i = 0; i < STORE_DEPTH; i++) begin
               if (i == 0) begin
                  digits_in[i] = {corr[i][2:0], mag_ff[WORD_BITS-1]};
               end else begin
                  digits_in[i] = {corr[i][2:0], corr[i-1][3]};
               end
            end
            mag_in = {mag_ff[WORD_BITS-2:0], 1'b0};
            if (bits_ff == '0) begin
               idx_in   = IDX_BITS'(STORE_DEPTH - 1);
               state_in = S_SCAN;
            end else begin
               bits_in = bits_ff - CNT_BITS'(1);
            end
         end
         S_SCAN: begin
            // Walk down past leading zero digits; the lowest digit always stays.
            if ((cur_digit != '0) || (idx_ff == '0)) begin
               pad_in = (mw_ff > count) ? (mw_ff - count) : '0;
               if (sign_ff) begin
                  state_in = S_SIGN;
               end else if (mw_ff > count) begin
                  state_in = S_PAD;
               end else begin
                  state_in = S_DIG;
               end
            end else begin
               idx_in = idx_ff - IDX_BITS'(1);
            end
         end
         S_SIGN: begin
            rsp_valid_in     = 1'b1;
            rsp_character_in = sign_ch_ff;
            state_in         = (pad_ff != '0) ? S_PAD : S_DIG;
         end
         S_PAD: begin
            rsp_valid_in     = 1'b1;
            rsp_character_in = itd_pkg::CHAR_ZERO;
            pad_in           = pad_ff - PAD_BITS'(1);
            if (pad_ff == PAD_BITS'(1)) begin
               state_in = S_DIG;
            end
         end
         S_DIG: begin
            rsp_valid_in     = 1'b1;
            rsp_character_in = itd_pkg::digit_char(cur_digit, upper_ff);
            rsp_last_in      = (idx_ff == '0);
            if (idx_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff - IDX_BITS'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      mag_ff           <= mag_in;
      bits_ff          <= bits_in;
      digits_ff        <= digits_in;
      idx_ff           <= idx_in;
      pad_ff           <= pad_in;
      mw_ff            <= mw_in;
      dec_ff           <= dec_in;
      upper_ff         <= upper_in;
      sign_ff          <= sign_in;
      sign_ch_ff       <= sign_ch_in;
      rsp_character_ff <= rsp_character_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   // An accepted item keeps the unit busy in the next cycle.
   `ASSERT_NEXT_CYCLE(a_accept_busy, clock, reset, accept, state_ff == S_CONV)
   // Every character beat comes from one of the emission states.
   `ASSERT_SAME_CYCLE(a_beat_source, clock, reset, rsp_valid,
                      $past(state_ff) == S_SIGN || $past(state_ff) == S_PAD ||
                      $past(state_ff) == S_DIG)
   // Padding is only emitted while a padding count remains.
   `ASSERT_SAME_CYCLE(a_pad_nonzero, clock, reset, state_ff == S_PAD, pad_ff != '0)
   // The final character of an item is never directly followed by another beat.
   `ASSERT_NEXT_CYCLE(a_last_gap, clock, reset, rsp_valid && rsp_last, !rsp_valid)

endmodule
